### hdl/nhpt_pkg.sv
// Shared types, codes and the control store of the next-hop path table.
package nhpt_pkg;

  localparam int NODES_DEFAULT = 128;

  // Request kinds.
  localparam logic [1:0] KIND_ADD    = 2'd0;
  localparam logic [1:0] KIND_REMOVE = 2'd1;
  localparam logic [1:0] KIND_QUERY  = 2'd2;
  localparam logic [1:0] KIND_UNUSED = 2'd3;

  // Sequencer steps; the enum order is the fall-through order of the program.
  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_ADD_DIRECT,
    ST_ADD_WALK,
    ST_REM_DIRECT,
    ST_REM_WALK,
    ST_FINAL_READ,
    ST_FINAL_LATCH,
    ST_Q_READ,
    ST_Q_START,
    ST_Q_CHECK,
    ST_Q_STEP,
    ST_BAD,
    ST_OUT
  } step_t;

  typedef enum logic [2:0] {
    RD_NONE,
    RD_FROM_TO,
    RD_I_FROM,
    RD_FROM_I,
    RD_CUR_TO
  } rd_sel_t;

  typedef enum logic [1:0] {
    WR_OFF,
    WR_DIRECT_TO,
    WR_DIRECT_NONE,
    WR_CLEAR
  } wr_sel_t;

  typedef enum logic [2:0] {
    DP_NONE,
    DP_HOP_RD,
    DP_Q_START,
    DP_Q_STEP,
    DP_BAD
  } dp_op_t;

  typedef enum logic [2:0] {
    J_NEXT,
    J_ALWAYS,
    J_DISPATCH,
    J_WALK,
    J_QSTOP,
    J_OUT,
    J_CLR
  } jump_t;

  // Write pending from a walk read issued in the previous cycle.
  typedef enum logic [1:0] {
    PEND_NONE,
    PEND_ADD,
    PEND_REM
  } pend_t;

  typedef struct packed {
    rd_sel_t rd;
    wr_sel_t wr;
    logic    ctr_clr;
    dp_op_t  dp;
    jump_t   jmp;
    step_t   target;
  } uc_word_t;

  // Control store: one word per step.
  function automatic uc_word_t uc_rom(step_t s);
    uc_word_t w;
    w = '{rd: RD_NONE, wr: WR_OFF, ctr_clr: 1'b0, dp: DP_NONE, jmp: J_NEXT,
          target: ST_IDLE};
    unique case (s)
      ST_CLEAR: begin
        w.wr = WR_CLEAR;
        w.jmp = J_CLR;
        w.target = ST_IDLE;
      end
      ST_IDLE: begin
        w.jmp = J_DISPATCH;
      end
      ST_ADD_DIRECT: begin
        w.wr = WR_DIRECT_TO;
        w.ctr_clr = 1'b1;
      end
      ST_ADD_WALK: begin
        w.rd = RD_I_FROM;
        w.jmp = J_WALK;
        w.target = ST_FINAL_READ;
      end
      ST_REM_DIRECT: begin
        w.wr = WR_DIRECT_NONE;
        w.ctr_clr = 1'b1;
      end
      ST_REM_WALK: begin
        w.rd = RD_FROM_I;
        w.jmp = J_WALK;
        w.target = ST_FINAL_READ;
      end
      ST_FINAL_READ: begin
        w.rd = RD_FROM_TO;
      end
      ST_FINAL_LATCH: begin
        w.dp = DP_HOP_RD;
        w.jmp = J_ALWAYS;
        w.target = ST_OUT;
      end
      ST_Q_READ: begin
        w.rd = RD_FROM_TO;
      end
      ST_Q_START: begin
        w.dp = DP_Q_START;
      end
      ST_Q_CHECK: begin
        w.rd = RD_CUR_TO;
        w.jmp = J_QSTOP;
        w.target = ST_OUT;
      end
      ST_Q_STEP: begin
        w.dp = DP_Q_STEP;
        w.jmp = J_ALWAYS;
        w.target = ST_Q_CHECK;
      end
      ST_BAD: begin
        w.dp = DP_BAD;
      end
      ST_OUT: begin
        w.jmp = J_OUT;
        w.target = ST_IDLE;
      end
      default: begin
        w.jmp = J_ALWAYS;
        w.target = ST_IDLE;
      end
    endcase
    return w;
  endfunction

endpackage

### hdl/next_hop_path_table.sv
// Next-hop path table: microcoded sequencer over one table RAM.
// Flow: an add or remove writes the direct entry and walks min(active_nodes, NODES) rows; a query
//   checks at most NODES hop entries; a self-edge add skips to the final read, an unused kind
//   to ST_BAD. One request at a time; the next is taken in the cycle after the result loads.
// Reset (rst, synchronous): a clearing pass writes "none" to every table entry, one entry a
//   cycle, 2**(2*ceil(log2(NODES))) entries (16384 at the default); requests wait, config does not.
module next_hop_path_table #(
  parameter int NODES = nhpt_pkg::NODES_DEFAULT
) (
  input  logic       clk,
  input  logic       rst,
  // configuration: active node count
  input  logic       cfg_we,
  input  logic [7:0] cfg_data,
  // request channel
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] kind,
  input  logic [6:0] from_node,
  input  logic [6:0] to_node,
  // result channel
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] next_hop,
  output logic [7:0] path_cost,
  output logic       reachable
);

  import nhpt_pkg::*;

  localparam int IDX_W   = $clog2(NODES);
  localparam int ENTRY_W = $clog2(NODES + 1);
  localparam int CTR_W   = $clog2(NODES + 1);
  localparam int ADDR_W  = 2 * IDX_W;
  localparam int DEPTH   = 1 << ADDR_W;
  localparam logic [ENTRY_W-1:0] HOP_NONE = ENTRY_W'(NODES);

  // Configuration register.
  logic [7:0] active_nodes;

  // Sequencer.
  step_t    step, step_next;
  uc_word_t uw;

  // Request fields, held for the whole request.
  logic [IDX_W-1:0] from_r;
  logic [IDX_W-1:0] to_r;
  logic [CTR_W-1:0] lim_r;
  logic             is_query;

  // Walk counter and the one-deep pending write behind it.
  logic [CTR_W-1:0] ctr;
  logic [IDX_W-1:0] widx;
  pend_t            pend;

  // Query walk and result holding.
  logic [ENTRY_W-1:0] cur;
  logic [ENTRY_W-1:0] cost;
  logic [ENTRY_W-1:0] hop;

  // Clearing pass address.
  logic [ADDR_W-1:0] clr_addr;

  // RAM port.
  logic               ram_we;
  logic [ADDR_W-1:0]  ram_waddr;
  logic [ENTRY_W-1:0] ram_wdata;
  logic               ram_re;
  logic [ADDR_W-1:0]  ram_raddr;
  logic [ENTRY_W-1:0] ram_rdata;

  logic             accept;
  logic             req_ok;
  logic [CTR_W-1:0] lim;
  logic             walk_go;
  logic             q_stop;
  logic             found;
  logic             out_load;
  step_t            dispatch;

  assign in_stall = (step != ST_IDLE);
  assign accept   = in_valid && !in_stall;
  assign out_load = (step == ST_OUT) && (!out_valid || !out_stall);

  // Row walks stop at the table size.
  assign lim = (32'(active_nodes) > NODES) ? CTR_W'(NODES) : CTR_W'(active_nodes);

  assign req_ok = (32'(from_node) < NODES) && (32'(to_node) < NODES) && (kind != KIND_UNUSED);

  // Entry point of the program for an incoming request.
  always_comb begin
    dispatch = ST_BAD;
    if (req_ok) begin
      case (kind)
        KIND_ADD:    dispatch = (from_node == to_node) ? ST_FINAL_READ : ST_ADD_DIRECT;
        KIND_REMOVE: dispatch = ST_REM_DIRECT;
        KIND_QUERY:  dispatch = ST_Q_READ;
        default:     dispatch = ST_BAD;
      endcase
    end
  end

  assign uw = uc_rom(step);

  // A walk step issues a read only while rows remain.
  assign walk_go = ((uw.rd == RD_I_FROM) || (uw.rd == RD_FROM_I)) && (ctr < lim_r);

  // Stop the hop chase on a broken chain, on arrival, or at the hop cap.
  assign q_stop = (cur >= HOP_NONE) || (cur == ENTRY_W'(to_r)) || (32'(cost) >= NODES);

  assign found = is_query && (cur == ENTRY_W'(to_r));

  // Next step.
  always_comb begin
    step_next = step;
    unique case (uw.jmp)
      J_NEXT:     step_next = step_t'(4'(step + 4'd1));
      J_ALWAYS:   step_next = uw.target;
      J_DISPATCH: step_next = accept ? dispatch : step;
      J_WALK:     step_next = walk_go ? step : uw.target;
      J_QSTOP:    step_next = q_stop ? uw.target : step_t'(4'(step + 4'd1));
      J_OUT:      step_next = out_load ? uw.target : step;
      J_CLR:      step_next = (&clr_addr) ? uw.target : step;
      default:    step_next = ST_IDLE;
    endcase
  end

  // Read address and enable.
  always_comb begin
    ram_re    = 1'b0;
    ram_raddr = {from_r, to_r};
    case (uw.rd)
      RD_FROM_TO: begin
        ram_re = 1'b1;
      end
      RD_I_FROM: begin
        ram_re    = walk_go;
        ram_raddr = {ctr[IDX_W-1:0], from_r};
      end
      RD_FROM_I: begin
        ram_re    = walk_go;
        ram_raddr = {from_r, ctr[IDX_W-1:0]};
      end
      RD_CUR_TO: begin
        ram_re    = 1'b1;
        ram_raddr = {cur[IDX_W-1:0], to_r};
      end
      default: ram_re = 1'b0;
    endcase
  end

  // Write port: direct writes and clearing from the control word, walk writes from the
  // pending slot. The two never coincide in one step.
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = {from_r, to_r};
    ram_wdata = HOP_NONE;
    case (uw.wr)
      WR_DIRECT_TO: begin
        ram_we    = 1'b1;
        ram_wdata = ENTRY_W'(to_r);
      end
      WR_DIRECT_NONE: begin
        ram_we = 1'b1;
      end
      WR_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_addr;
      end
      default: ram_we = 1'b0;
    endcase
    case (pend)
      PEND_ADD: begin
        // Row widx reaches from: it reaches to by the same first hop, except to itself.
        if (ram_rdata != HOP_NONE) begin
          ram_we    = 1'b1;
          ram_waddr = {widx, to_r};
          ram_wdata = (widx == to_r) ? HOP_NONE : ram_rdata;
        end
      end
      PEND_REM: begin
        // Drop every entry of row from that goes through to.
        if (ram_rdata == ENTRY_W'(to_r)) begin
          ram_we    = 1'b1;
          ram_waddr = {from_r, widx};
        end
      end
      default: ram_we = ram_we;
    endcase
  end

  nhpt_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      step         <= ST_CLEAR;
      clr_addr     <= '0;
      pend         <= PEND_NONE;
      out_valid    <= 1'b0;
      active_nodes <= 8'd1;
    end else begin
      step <= step_next;
      if (uw.wr == WR_CLEAR) begin
        clr_addr <= clr_addr + 1'b1;
      end
      if (walk_go) begin
        pend <= (uw.rd == RD_I_FROM) ? PEND_ADD : PEND_REM;
      end else begin
        pend <= PEND_NONE;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      if (cfg_we) begin
        active_nodes <= cfg_data;
      end
    end
  end

  // Datapath.
  always_ff @(posedge clk) begin
    if (accept) begin
      from_r   <= IDX_W'(from_node);
      to_r     <= IDX_W'(to_node);
      lim_r    <= lim;
      is_query <= req_ok && (kind == KIND_QUERY);
    end
    if (uw.ctr_clr) begin
      ctr <= '0;
    end else if (walk_go) begin
      ctr  <= ctr + 1'b1;
      widx <= ctr[IDX_W-1:0];
    end
    case (uw.dp)
      DP_HOP_RD: hop <= ram_rdata;
      DP_Q_START: begin
        hop  <= ram_rdata;
        cur  <= ram_rdata;
        cost <= ENTRY_W'(1);
      end
      DP_Q_STEP: begin
        cur  <= ram_rdata;
        cost <= cost + 1'b1;
      end
      DP_BAD:  hop <= HOP_NONE;
      default: hop <= hop;
    endcase
    if (out_load) begin
      next_hop  <= 8'(hop);
      path_cost <= found ? 8'(cost) : 8'd0;
      reachable <= found;
    end
  end

  // A pending add write targets column to while the walk reads column from.
  a_pend_cols: assert property (@(posedge clk) disable iff (rst)
    (pend == PEND_ADD) |-> (from_r != to_r))
    else $error("add walk write collides with read column");

  a_walk_bound: assert property (@(posedge clk) disable iff (rst)
    ((step == ST_ADD_WALK) || (step == ST_REM_WALK)) |-> (ctr <= lim_r))
    else $error("row walk ran past its limit");

  a_cost_bound: assert property (@(posedge clk) disable iff (rst)
    ((step == ST_OUT) && is_query) |-> (32'(cost) <= NODES))
    else $error("query hop count above table size");

  a_out_src: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> ($past(step) == ST_OUT))
    else $error("result raised outside the output step");

endmodule

### hdl/nhpt_ram.sv
// Generic single-write, single-read RAM with registered read data.
module nhpt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### tb/next_hop_path_table_tb.sv
// Self-checking testbench for the next-hop path table: directed rows, then random edge traffic.
module next_hop_path_table_tb;
  import nhpt_pkg::*;

  localparam int NODE_COUNT = 128;
  localparam logic [7:0] HOP_NONE = 8'd128;
  localparam int LIMIT_CYCLES = 1_000_000;
  // Let stray results show up after the last expected one drains.
  localparam int DRAIN_CYCLES = 300;
  localparam int PHASE_REQUESTS = 60;
  localparam int DIRECTED_ROWS = 21;

  typedef struct packed {
    logic [7:0] next_hop;
    logic [7:0] path_cost;
    logic       reachable;
  } route_result_t;

  typedef struct packed {
    logic [1:0]    kind;
    logic [6:0]    from_node;
    logic [6:0]    to_node;
    logic          known;
    route_result_t result;
  } directed_row_t;

  localparam route_result_t NO_ROUTE = '{HOP_NONE, 8'd0, 1'b0};

  logic       clk;
  logic       rst;
  logic       cfg_we;
  logic [7:0] cfg_data;
  logic       in_valid;
  logic       in_stall;
  logic [1:0] kind;
  logic [6:0] from_node;
  logic [6:0] to_node;
  logic       out_valid;
  logic       out_stall;
  logic [7:0] next_hop;
  logic [7:0] path_cost;
  logic       reachable;

  // Shadow copy of the routing table and the active node count.
  logic [7:0]    hop_mem [NODE_COUNT][NODE_COUNT];
  logic [7:0]    active_count;
  route_result_t hop_results_due [$];
  int            mismatch_count = 0;
  int            routing_requests = 0;
  int            cycle_count = 0;
  bit            idling_on = 1'b1;

  // Active node settings, one per random phase; the last phase runs without idling.
  logic [7:0] active_settings [8] = '{8'd1, 8'd0, 8'd128, 8'd255, 8'd6, 8'd20, 8'd2, 8'd128};

  // Directed rows run with eight active nodes. Typed results are the ones that are obvious:
  // empty table, unused kind, self edge, an edge each way, their removal and the last query.
  // The rest, predicted, build a hop cycle through a stale entry and a broken chain.
  directed_row_t directed_rows [DIRECTED_ROWS] = '{
    '{KIND_QUERY,   7'd0,   7'd127, 1'b1, NO_ROUTE},
    '{KIND_UNUSED,  7'd127, 7'd0,   1'b1, NO_ROUTE},
    '{KIND_ADD,     7'd5,   7'd5,   1'b1, NO_ROUTE},
    '{KIND_ADD,     7'd0,   7'd127, 1'b1, '{8'd127, 8'd0, 1'b0}},
    '{KIND_QUERY,   7'd0,   7'd127, 1'b1, '{8'd127, 8'd1, 1'b1}},
    '{KIND_ADD,     7'd127, 7'd0,   1'b1, '{8'd0, 8'd0, 1'b0}},
    '{KIND_QUERY,   7'd127, 7'd0,   1'b1, '{8'd0, 8'd1, 1'b1}},
    '{KIND_REMOVE,  7'd0,   7'd127, 1'b1, NO_ROUTE},
    '{KIND_QUERY,   7'd0,   7'd127, 1'b1, NO_ROUTE},
    '{KIND_REMOVE,  7'd127, 7'd0,   1'b1, NO_ROUTE},
    '{KIND_UNUSED,  7'd0,   7'd127, 1'b1, NO_ROUTE},
    '{KIND_ADD,     7'd2,   7'd1,   1'b0, NO_ROUTE},
    '{KIND_ADD,     7'd1,   7'd4,   1'b0, NO_ROUTE},
    '{KIND_REMOVE,  7'd1,   7'd4,   1'b0, NO_ROUTE},
    '{KIND_ADD,     7'd1,   7'd2,   1'b0, NO_ROUTE},
    '{KIND_ADD,     7'd2,   7'd3,   1'b0, NO_ROUTE},
    '{KIND_REMOVE,  7'd2,   7'd3,   1'b0, NO_ROUTE},
    '{KIND_ADD,     7'd3,   7'd4,   1'b0, NO_ROUTE},
    '{KIND_QUERY,   7'd1,   7'd4,   1'b0, NO_ROUTE},
    '{KIND_QUERY,   7'd1,   7'd3,   1'b0, NO_ROUTE},
    '{KIND_QUERY,   7'd2,   7'd1,   1'b1, '{8'd1, 8'd1, 1'b1}}
  };

  next_hop_path_table #(.NODES(NODE_COUNT)) dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .kind      (kind),
    .from_node (from_node),
    .to_node   (to_node),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .next_hop  (next_hop),
    .path_cost (path_cost),
    .reachable (reachable)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Apply one request to the shadow table and return the result it should produce.
  function automatic route_result_t route_step(logic [1:0] op, logic [6:0] src, logic [6:0] dst);
    route_result_t res;
    int            rows;
    int            cost;
    logic [7:0]    cur;
    res = NO_ROUTE;
    if (op == KIND_UNUSED) return res;
    // Row walks stop at the table size; zero active nodes walk nothing.
    rows = (active_count > NODE_COUNT) ? NODE_COUNT : int'(active_count);
    case (op)
      KIND_ADD: begin
        // A self edge leaves the table alone.
        if (src != dst) begin
          hop_mem[src][dst] = {1'b0, dst};
          for (int i = 0; i < rows; i++) begin
            if (hop_mem[i][src] != HOP_NONE)
              hop_mem[i][dst] = (i == int'(dst)) ? HOP_NONE : hop_mem[i][src];
          end
        end
      end
      KIND_REMOVE: begin
        hop_mem[src][dst] = HOP_NONE;
        for (int i = 0; i < rows; i++) begin
          if (hop_mem[src][i] == {1'b0, dst}) hop_mem[src][i] = HOP_NONE;
        end
      end
      default: begin
        // Follow hops toward dst; a none entry or a walk past NODES hops is unreachable.
        cur = hop_mem[src][dst];
        cost = (cur >= HOP_NONE) ? 0 : 1;
        while (cost != 0 && cur != {1'b0, dst}) begin
          if (cost >= NODE_COUNT) begin
            cost = 0;
          end else begin
            cur = hop_mem[cur[6:0]][dst];
            cost = (cur >= HOP_NONE) ? 0 : cost + 1;
          end
        end
        res.path_cost = cost[7:0];
        res.reachable = (cost != 0);
      end
    endcase
    res.next_hop = hop_mem[src][dst];
    return res;
  endfunction

  // Hold the request until accepted, record its expected result, then maybe idle a burst.
  task automatic send_request(input logic [1:0] op, input logic [6:0] src, input logic [6:0] dst,
                              input logic known, input route_result_t typed);
    route_result_t predicted;
    in_valid <= 1'b1;
    kind <= op;
    from_node <= src;
    to_node <= dst;
    do @(posedge clk); while (in_stall);
    predicted = route_step(op, src, dst);
    hop_results_due.push_back(known ? typed : predicted);
    if (op != KIND_UNUSED && !(op == KIND_ADD && src == dst)) routing_requests++;
    if (idling_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
  endtask

  // Drain all outstanding results, then write the active node count.
  task automatic write_active_nodes(input logic [7:0] value);
    in_valid <= 1'b0;
    while (hop_results_due.size() != 0) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_data <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    active_count = value;
  endtask

  // Result side: stall in random bursts while idling is enabled.
  initial begin
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (idling_on && $urandom_range(0, 3) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 8)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  // Compare every accepted result with the oldest expectation.
  always @(posedge clk) begin
    route_result_t due;
    if (!rst && out_valid && !out_stall) begin
      if (hop_results_due.size() == 0) begin
        $error("unexpected result: next_hop %0d path_cost %0d reachable %0d",
               next_hop, path_cost, reachable);
        mismatch_count++;
      end else begin
        due = hop_results_due.pop_front();
        if (next_hop !== due.next_hop) begin
          $error("next_hop: expected %0d, actual %0d", due.next_hop, next_hop);
          mismatch_count++;
        end
        if (path_cost !== due.path_cost) begin
          $error("path_cost: expected %0d, actual %0d", due.path_cost, path_cost);
          mismatch_count++;
        end
        if (reachable !== due.reachable) begin
          $error("reachable: expected %0d, actual %0d", due.reachable, reachable);
          mismatch_count++;
        end
      end
    end
  end

  // Watchdog: covers the clearing pass plus every request at its slowest, several times over.
  initial begin
    while (cycle_count < LIMIT_CYCLES) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Verification failed");
    $finish;
  end

  initial begin
    logic [6:0] order [NODE_COUNT];
    logic [6:0] swap;
    int         rows;
    int         pool;
    int         span;
    int         pick;
    int         target;
    bit         long_chain;

    rst <= 1'b1;
    cfg_we <= 1'b0;
    cfg_data <= 8'd0;
    in_valid <= 1'b0;
    kind <= KIND_ADD;
    from_node <= 7'd0;
    to_node <= 7'd0;
    for (int r = 0; r < NODE_COUNT; r++)
      for (int c = 0; c < NODE_COUNT; c++) hop_mem[r][c] = HOP_NONE;
    active_count = 8'd1;

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Config is taken during the clearing pass; requests wait for it to finish.
    write_active_nodes(8'd8);
    for (int r = 0; r < DIRECTED_ROWS; r++) begin
      send_request(directed_rows[r].kind, directed_rows[r].from_node, directed_rows[r].to_node,
                   directed_rows[r].known, directed_rows[r].result);
    end

    foreach (active_settings[p]) begin
      write_active_nodes(active_settings[p]);
      idling_on = (p != $size(active_settings) - 1);
      rows = (active_settings[p] > NODE_COUNT) ? NODE_COUNT : int'(active_settings[p]);
      // Tiny active counts still get a handful of nodes for direct entries.
      pool = (rows < 4) ? 8 : rows;
      long_chain = (rows == NODE_COUNT);
      target = routing_requests + PHASE_REQUESTS;
      while (routing_requests < target) begin
        if ($urandom_range(0, 9) < 7) begin
          // Build a chain over distinct nodes in order, so the head learns every hop if its row is walked.
          for (int n = 0; n < pool; n++) order[n] = 7'(n);
          for (int n = pool - 1; n > 0; n--) begin
            pick = $urandom_range(0, n);
            swap = order[n];
            order[n] = order[pick];
            order[pick] = swap;
          end
          span = long_chain ? $urandom_range(40, 100) : $urandom_range(1, 6);
          long_chain = 1'b0;
          if (span > pool - 1) span = pool - 1;
          for (int n = 0; n < span; n++)
            send_request(KIND_ADD, order[n], order[n + 1], 1'b0, NO_ROUTE);
          send_request(KIND_QUERY, order[0], order[span], 1'b0, NO_ROUTE);
          // Break a link now and then and walk the chain again.
          if ($urandom_range(0, 2) == 0) begin
            pick = $urandom_range(0, span - 1);
            send_request(KIND_REMOVE, order[pick], order[pick + 1], 1'b0, NO_ROUTE);
            send_request(KIND_QUERY, order[0], order[span], 1'b0, NO_ROUTE);
          end
          send_request(KIND_QUERY, order[$urandom_range(0, span)], order[span], 1'b0, NO_ROUTE);
        end else begin
          // Noise: any kind, nodes from the pool or the whole index range.
          repeat ($urandom_range(1, 4)) begin
            if ($urandom_range(0, 1) == 0)
              send_request(2'($urandom_range(0, 3)), 7'($urandom_range(0, 127)),
                           7'($urandom_range(0, 127)), 1'b0, NO_ROUTE);
            else
              send_request(2'($urandom_range(0, 3)), 7'($urandom_range(0, pool - 1)),
                           7'($urandom_range(0, pool - 1)), 1'b0, NO_ROUTE);
          end
        end
      end
    end

    in_valid <= 1'b0;
    while (hop_results_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && hop_results_due.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

### sim.f
hdl/nhpt_pkg.sv
hdl/nhpt_ram.sv
hdl/next_hop_path_table.sv
tb/next_hop_path_table_tb.sv
